// ===== rtl/sosr_pkg.sv =====
package sosr_pkg;

  // Grid size of the controlled street network.
  localparam int ROWS = 4;
  localparam int COLS = 4;
  localparam int CELLS = ROWS * COLS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam int TIMER_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GREEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEMAND_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT = 2'd3;

  typedef struct packed {
    logic [1:0] row_index;
    logic [1:0] col_index;
    logic [7:0] h_demand_sum;
    logic [7:0] v_demand_sum;
    logic [7:0] h_near_count;
    logic [7:0] v_near_count;
    logic [7:0] h_close_count;
    logic [7:0] v_close_count;
    logic       h_blocked;
    logic       v_blocked;
  } in_item_t;

  typedef struct packed {
    logic h_green;
    logic v_green;
    logic phase_switched;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_green_time;
    logic [15:0] max_wait_time;
    logic [7:0]  demand_threshold;
    logic [7:0]  close_limit;
  } cfg_t;

  // Stored state of one intersection.
  typedef struct packed {
    logic               h_light;
    logic               v_light;
    logic [TIMER_W-1:0] h_timer;
    logic [TIMER_W-1:0] v_timer;
  } cell_state_t;

  localparam cell_state_t CELL_RESET = '{h_light: 1'b0, v_light: 1'b1,
                                         h_timer: '0, v_timer: '0};

  // Table slot of an intersection; coordinates beyond the grid saturate.
  function automatic logic [CELL_W-1:0] cell_of(input logic [1:0] row,
                                                input logic [1:0] col);
    int r;
    int c;
    r = (int'(row) >= ROWS) ? ROWS - 1 : int'(row);
    c = (int'(col) >= COLS) ? COLS - 1 : int'(col);
    return CELL_W'(r * COLS + c);
  endfunction

endpackage

// ===== rtl/sosr_table.sv =====
module sosr_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sosr_pkg::CELL_W-1:0] rd_cell,
  output sosr_pkg::cell_state_t       rd_state,
  input  logic                        wr_en,
  input  logic [sosr_pkg::CELL_W-1:0] wr_cell,
  input  sosr_pkg::cell_state_t       wr_state
);
  import sosr_pkg::*;

  cell_state_t state_r [CELLS];

  // Reset loads every intersection with horizontal red, vertical green.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        state_r[i] <= CELL_RESET;
      end
    end else if (wr_en) begin
      state_r[wr_cell] <= wr_state;
    end
  end

  assign rd_state = state_r[rd_cell];

endmodule

// ===== rtl/sosr_rules.sv =====
module sosr_rules (
  input  sosr_pkg::in_item_t    item,
  input  sosr_pkg::cfg_t        cfg,
  input  sosr_pkg::cell_state_t cur,
  output sosr_pkg::cell_state_t nxt,
  output logic                  switched
);
  import sosr_pkg::*;

  logic               hl;
  logic               vl;
  logic [TIMER_W-1:0] ht;
  logic [TIMER_W-1:0] vt;
  logic               halt;
  logic               do_sw;
  logic               demand_sw;

  // Rule chain, highest priority first.
  always_comb begin
    hl = cur.h_light;
    vl = cur.v_light;
    ht = cur.h_timer;
    vt = cur.v_timer;
    halt = 1'b0;
    do_sw = 1'b0;

    // Both red: give one approach green, unless both are blocked.
    if (!hl && !vl) begin
      if (!item.h_blocked) begin
        ht = '0; vt = '0; hl = 1'b1;
      end else if (!item.v_blocked) begin
        ht = '0; vt = '0; vl = 1'b1;
      end else begin
        halt = 1'b1;
      end
    end

    // A blocked approach goes red.
    if (!halt && item.h_blocked) begin
      hl = 1'b0; ht = '0;
    end
    if (!halt && item.v_blocked) begin
      vl = 1'b0; vt = '0;
    end

    demand_sw = (!item.v_blocked && hl && item.v_demand_sum >= cfg.demand_threshold) ||
                (!item.h_blocked && vl && item.h_demand_sum >= cfg.demand_threshold);

    if (!halt) begin
      priority if (!item.v_blocked && hl && item.v_near_count != 8'd0 &&
                   item.h_near_count == 8'd0) begin
        do_sw = 1'b1;
      end else if (!item.h_blocked && vl && item.h_near_count != 8'd0 &&
                   item.v_near_count == 8'd0) begin
        do_sw = 1'b1;
      end else if (hl && item.h_close_count != 8'd0 &&
                   item.h_close_count <= cfg.close_limit) begin
        do_sw = 1'b0;
      end else if (vl && item.v_close_count != 8'd0 &&
                   item.v_close_count <= cfg.close_limit) begin
        do_sw = 1'b0;
      end else if (hl && ht >= cfg.min_green_time) begin
        do_sw = (vt >= cfg.max_wait_time) || demand_sw;
      end else if (vl && vt >= cfg.min_green_time) begin
        do_sw = (ht >= cfg.max_wait_time) || demand_sw;
      end else begin
        do_sw = 1'b0;
      end
    end

    // A full switch clears both timers and swaps the lights.
    if (do_sw) begin
      vl = hl;
      hl = !hl;
      ht = '0;
      vt = '0;
    end

    nxt.h_light = hl;
    nxt.v_light = vl;
    nxt.h_timer = (ht == TIMER_MAX) ? ht : ht + 1'b1;
    nxt.v_timer = (vt == TIMER_MAX) ? vt : vt + 1'b1;
    switched = do_sw;
  end

endmodule

// ===== rtl/self_organizing_signal_rules.sv =====
// Self-organising traffic signal controller for a grid of intersections.
// Each input beat names one intersection and carries its sensor counts; the
// block runs the prioritised rule chain on that intersection's stored lights
// and phase timers and returns one result beat with both lights and a flag
// that marks a full phase switch. A beat is taken on any cycle with start
// high (busy is never raised), so one beat per cycle is sustained; its
// result passes the input and result registers, is on out_valid for one
// cycle only and the receiver cannot stall it. The intersection table is
// read and written in the same stage, so back-to-back beats to the same
// intersection see each other's updates. The user must write configuration
// through cfg_ only while no beat is in flight; the block does not enforce it.
module self_organizing_signal_rules (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  sosr_pkg::in_item_t              in_item,
  output logic                            out_valid,
  output sosr_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [sosr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sosr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sosr_pkg::*;

  cfg_t        cfg_r;
  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [CELL_W-1:0] cell_idx;
  cell_state_t cur_state;
  cell_state_t nxt_state;
  logic        switched;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_GREEN:   cfg_r.min_green_time <= cfg_data;
        CFG_MAX_WAIT:    cfg_r.max_wait_time <= cfg_data;
        CFG_DEMAND_THR:  cfg_r.demand_threshold <= cfg_data[7:0];
        CFG_CLOSE_LIMIT: cfg_r.close_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item_r <= in_item;
    end
  end

  assign cell_idx = cell_of(in_item_r.row_index, in_item_r.col_index);

  sosr_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_cell  (cell_idx),
    .rd_state (cur_state),
    .wr_en    (in_valid_r),
    .wr_cell  (cell_idx),
    .wr_state (nxt_state)
  );

  sosr_rules u_rules (
    .item     (in_item_r),
    .cfg      (cfg_r),
    .cur      (cur_state),
    .nxt      (nxt_state),
    .switched (switched)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_item_r.h_green <= nxt_state.h_light;
      out_item_r.v_green <= nxt_state.v_light;
      out_item_r.phase_switched <= switched;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  // Every accepted beat produces a result through the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |=> !out_valid)
    else $error("result without an accepted beat");

  // A full switch always leaves exactly one approach green.
  a_switch_one_green: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.phase_switched) |-> (out_item.h_green != out_item.v_green))
    else $error("switch left both lights equal");

endmodule

// ===== verif/self_organizing_signal_rules_test.sv =====
`timescale 1ns / 1ps

module self_organizing_signal_rules_test;
  import sosr_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_GREEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted intersection table and register copies.
  logic              sig_h_green [CELLS];
  logic              sig_v_green [CELLS];
  logic [TIMER_W-1:0] h_phase_ticks [CELLS];
  logic [TIMER_W-1:0] v_phase_ticks [CELLS];
  logic [15:0]       min_green_q;
  logic [15:0]       max_wait_q;
  logic [7:0]        demand_thr_q;
  logic [7:0]        close_lim_q;

  out_item_t light_expect_q [$];
  bit        idle_en = 1'b1;
  int        beats_sent = 0;
  int        lights_checked = 0;
  int        mismatch_count = 0;
  int        settings_loaded = 0;

  self_organizing_signal_rules u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Full switch: both timers clear and the lights swap.
  function automatic void swap_lights(input int c);
    h_phase_ticks[c] = '0;
    v_phase_ticks[c] = '0;
    if (!sig_h_green[c]) begin
      sig_h_green[c] = 1'b1;
      sig_v_green[c] = 1'b0;
    end else begin
      sig_h_green[c] = 1'b0;
      sig_v_green[c] = 1'b1;
    end
  endfunction

  // Prioritised rule chain on one intersection; returns 1 on a full switch.
  function automatic bit run_rule_chain(input int c, input in_item_t it);
    // Both red: bring back one green, unless both sides are blocked.
    if (!sig_h_green[c] && !sig_v_green[c]) begin
      if (!it.h_blocked) begin
        h_phase_ticks[c] = '0;
        v_phase_ticks[c] = '0;
        sig_h_green[c] = 1'b1;
        sig_v_green[c] = 1'b0;
      end else if (!it.v_blocked) begin
        h_phase_ticks[c] = '0;
        v_phase_ticks[c] = '0;
        sig_h_green[c] = 1'b0;
        sig_v_green[c] = 1'b1;
      end else begin
        return 1'b0;
      end
    end
    // A blocked approach goes red.
    if (it.h_blocked) begin
      sig_h_green[c] = 1'b0;
      h_phase_ticks[c] = '0;
    end
    if (it.v_blocked) begin
      sig_v_green[c] = 1'b0;
      v_phase_ticks[c] = '0;
    end
    // A queue waiting alone on red is served at once.
    if (!it.v_blocked && sig_h_green[c] && it.v_near_count >= 8'd1 &&
        it.h_near_count == 8'd0) begin
      swap_lights(c);
      return 1'b1;
    end
    if (!it.h_blocked && sig_v_green[c] && it.h_near_count >= 8'd1 &&
        it.v_near_count == 8'd0) begin
      swap_lights(c);
      return 1'b1;
    end
    // A short platoon close to the line keeps its green.
    if (sig_h_green[c] && it.h_close_count > 8'd0 && it.h_close_count <= close_lim_q)
      return 1'b0;
    if (sig_v_green[c] && it.v_close_count > 8'd0 && it.v_close_count <= close_lim_q)
      return 1'b0;
    // Minimum green, then the maximum wait of the red side.
    if (sig_h_green[c] && h_phase_ticks[c] >= min_green_q) begin
      if (v_phase_ticks[c] >= max_wait_q) begin
        swap_lights(c);
        return 1'b1;
      end
    end else if (sig_v_green[c] && v_phase_ticks[c] >= min_green_q) begin
      if (h_phase_ticks[c] >= max_wait_q) begin
        swap_lights(c);
        return 1'b1;
      end
    end else begin
      return 1'b0;
    end
    // Accumulated demand on the red side.
    if (!it.v_blocked && sig_h_green[c] && it.v_demand_sum >= demand_thr_q) begin
      swap_lights(c);
      return 1'b1;
    end
    if (!it.h_blocked && sig_v_green[c] && it.h_demand_sum >= demand_thr_q) begin
      swap_lights(c);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the light beat for one tick and advances the table.
  function automatic out_item_t predict_lights(input in_item_t it);
    int        r;
    int        col;
    int        c;
    bit        switched;
    out_item_t res;
    r = int'(it.row_index);
    col = int'(it.col_index);
    if (r >= ROWS) r = ROWS - 1;
    if (col >= COLS) col = COLS - 1;
    c = r * COLS + col;
    switched = run_rule_chain(c, it);
    if (h_phase_ticks[c] != TIMER_MAX) h_phase_ticks[c] = h_phase_ticks[c] + 1'b1;
    if (v_phase_ticks[c] != TIMER_MAX) v_phase_ticks[c] = v_phase_ticks[c] + 1'b1;
    res.h_green = sig_h_green[c];
    res.v_green = sig_v_green[c];
    res.phase_switched = switched;
    return res;
  endfunction

  function automatic in_item_t tick_beat(input int row, input int col,
                                         input int hd, input int vd,
                                         input int hn, input int vn,
                                         input int hc, input int vc,
                                         input bit hb, input bit vb);
    in_item_t it;
    it.row_index = 2'(row);
    it.col_index = 2'(col);
    it.h_demand_sum = 8'(hd);
    it.v_demand_sum = 8'(vd);
    it.h_near_count = 8'(hn);
    it.v_near_count = 8'(vn);
    it.h_close_count = 8'(hc);
    it.v_close_count = 8'(vc);
    it.h_blocked = hb;
    it.v_blocked = vb;
    return it;
  endfunction

  // Mostly plausible sensor counts on a few intersections, some pure noise.
  function automatic int sensor_count();
    return ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 6);
  endfunction

  function automatic in_item_t random_beat();
    logic [63:0] raw;
    in_item_t    it;
    if ($urandom_range(0, 99) < 20) begin
      raw = {$urandom, $urandom};
      it = raw[$bits(in_item_t)-1:0];
    end else begin
      it = tick_beat($urandom_range(0, 1), $urandom_range(0, 3),
                     $urandom_range(0, 40), $urandom_range(0, 40),
                     sensor_count(), sensor_count(), sensor_count(), sensor_count(),
                     $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12);
    end
    return it;
  endfunction

  // Sends one tick beat; start stays high after acceptance for the next one.
  task automatic send_beat(input in_item_t it);
    if (idle_en && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    light_expect_q.push_back(predict_lights(it));
    beats_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (light_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers in index order.
  task automatic load_config(input logic [15:0] min_g, input logic [15:0] max_w,
                             input logic [15:0] thr_data, input logic [15:0] close_data);
    logic [15:0]          vals [4];
    logic [CFG_IDX_W-1:0] regs [4];
    vals = '{min_g, max_w, thr_data, close_data};
    regs = '{CFG_MIN_GREEN, CFG_MAX_WAIT, CFG_DEMAND_THR, CFG_CLOSE_LIMIT};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      case (regs[i])
        CFG_MIN_GREEN:   min_green_q = vals[i];
        CFG_MAX_WAIT:    max_wait_q = vals[i];
        CFG_DEMAND_THR:  demand_thr_q = vals[i][7:0];
        CFG_CLOSE_LIMIT: close_lim_q = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  // Each light beat is compared with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (light_expect_q.size() == 0) begin
        $display("%0t ns: light beat with nothing expected, got h=%b v=%b sw=%b",
                 $time, out_item.h_green, out_item.v_green, out_item.phase_switched);
        mismatch_count++;
      end else begin
        want = light_expect_q.pop_front();
        lights_checked++;
        if (want.h_green !== out_item.h_green || want.v_green !== out_item.v_green ||
            want.phase_switched !== out_item.phase_switched) begin
          $display("%0t ns: light mismatch, expected h=%b v=%b sw=%b, got h=%b v=%b sw=%b",
                   $time, want.h_green, want.v_green, want.phase_switched,
                   out_item.h_green, out_item.v_green, out_item.phase_switched);
          mismatch_count++;
        end
      end
    end
  end

  // Registers still at their reset values: zero and full-scale fields.
  task automatic test_reset_defaults();
    send_beat(tick_beat(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_beat(tick_beat(3, 3, 255, 255, 255, 255, 255, 255, 1'b1, 1'b1));
    wait_idle();
  endtask

  // One walk through each rule of the chain.
  task automatic test_directed_rules();
    load_config(16'd2, 16'd6, 16'd10, 16'd3);
    // Both red, both blocked, and restoring a green either way.
    send_beat(tick_beat(1, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    send_beat(tick_beat(1, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_beat(tick_beat(1, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_beat(tick_beat(1, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    send_beat(tick_beat(1, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Lone queues on either approach.
    send_beat(tick_beat(1, 0, 0, 0, 0, 4, 0, 0, 1'b0, 1'b0));
    send_beat(tick_beat(1, 0, 0, 0, 3, 0, 0, 0, 1'b0, 1'b0));
    // Close platoon at and beyond the limit, then demand against min green.
    send_beat(tick_beat(2, 1, 0, 0, 0, 0, 0, 2, 1'b0, 1'b0));
    send_beat(tick_beat(2, 1, 0, 0, 0, 0, 0, 3, 1'b0, 1'b0));
    send_beat(tick_beat(2, 1, 20, 0, 0, 0, 0, 4, 1'b0, 1'b0));
    send_beat(tick_beat(2, 1, 5, 5, 0, 0, 0, 0, 1'b0, 1'b0));
    send_beat(tick_beat(2, 1, 0, 9, 0, 0, 0, 0, 1'b0, 1'b0));
    send_beat(tick_beat(2, 1, 0, 10, 0, 0, 0, 0, 1'b0, 1'b0));
    // No demand at all: only the maximum wait can switch; then demand on a blocked approach.
    repeat (8) send_beat(tick_beat(3, 2, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_beat(tick_beat(3, 2, 255, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    wait_idle();
  endtask

  // A close platoon holds the green for a long phase; the maximum wait then fires.
  task automatic test_long_hold();
    load_config(16'd50, 16'd60, 16'h00FF, 16'h00FF);
    idle_en = 1'b0;
    repeat (60) send_beat(tick_beat(3, 0, 0, 0, 0, 0, 0, 1, 1'b0, 1'b0));
    send_beat(tick_beat(3, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_beat(tick_beat(3, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    idle_en = 1'b1;
    wait_idle();
  endtask

  // Random traffic over several register settings, the extremes included.
  task automatic test_random_traffic();
    for (int p = 0; p < 7; p++) begin
      if (p == 0) load_config(16'd0, 16'd0, 16'd0, 16'd0);
      else if (p == 1) load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else load_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 15)),
                       {8'($urandom), 8'($urandom_range(0, 40))},
                       {8'($urandom), 8'($urandom_range(0, 5))});
      idle_en = (p != 4);
      repeat (140) send_beat(random_beat());
      wait_idle();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      sig_h_green[i] = 1'b0;
      sig_v_green[i] = 1'b1;
      h_phase_ticks[i] = '0;
      v_phase_ticks[i] = '0;
    end
    min_green_q = '0;
    max_wait_q = '0;
    demand_thr_q = '0;
    close_lim_q = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_rules();
    test_long_hold();
    test_random_traffic();

    $display("Sent %0d tick beats and checked %0d light beats under %0d register settings,",
             beats_sent, lights_checked, settings_loaded);
    $display("covering every rule, blocked approaches and a long held green phase.");
    if (mismatch_count == 0) begin
      $display("self_organizing_signal_rules verification clean");
    end else begin
      $display("self_organizing_signal_rules verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("self_organizing_signal_rules verification failed");
    $finish;
  end

endmodule
